>>> hw/rtl/hcbp_pkg.sv
// Shared constants and command codes for the Huffman code bit packer.
package hcbp_pkg;

	// Command codes carried in the cmd field of an input request.
	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	localparam int MAX_CODE_LEN_DEF = 32;
	localparam int CODE_BITS_W      = 32;
	localparam int CODE_LEN_W       = 6;
	localparam int SYMBOL_W         = 8;
	localparam int BYTE_W           = 8;
	localparam int NUM_SYMBOLS      = 256;
	localparam int QUEUE_DEPTH      = 4;

	// Longest code actually kept: the parameter, but never beyond the port width.
	function automatic int len_cap(input int max_code_len);
		return (max_code_len < CODE_BITS_W) ? max_code_len : CODE_BITS_W;
	endfunction

endpackage

>>> hw/rtl/hcbp_item_if.sv
// Input channel of the bit packer: one command request per handshake.
interface hcbp_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] symbol;
	logic [31:0] code_bits;
	logic [5:0] code_len;

	modport source (output valid, output cmd, output symbol, output code_bits,
		output code_len, input ready);
	modport sink (input valid, input cmd, input symbol, input code_bits,
		input code_len, output ready);
endinterface

>>> hw/rtl/hcbp_result_if.sv
// Output channel of the bit packer: one packed byte per handshake.
interface hcbp_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink (input valid, input out_byte, input last, output ready);
endinterface

>>> hw/rtl/hcbp_front.sv
// Front end: code table storage, lookup and classification of requests.
module hcbp_front #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            cmd,
	input  logic [hcbp_pkg::SYMBOL_W-1:0]         symbol,
	input  logic [hcbp_pkg::CODE_BITS_W-1:0]      code_bits,
	input  logic [hcbp_pkg::CODE_LEN_W-1:0]       code_len,
	output logic                                  push,
	input  logic                                  q_full,
	output logic [hcbp_pkg::len_cap(MAX_CODE_LEN)+hcbp_pkg::CODE_LEN_W:0] push_data
);
	localparam int LEN_CAP = hcbp_pkg::len_cap(MAX_CODE_LEN);
	localparam logic [hcbp_pkg::CODE_LEN_W-1:0] LEN_CAP_V =
		hcbp_pkg::CODE_LEN_W'(LEN_CAP);

	logic [LEN_CAP-1:0]                code_mem [hcbp_pkg::NUM_SYMBOLS];
	logic [hcbp_pkg::CODE_LEN_W-1:0]   len_mem  [hcbp_pkg::NUM_SYMBOLS];
	logic [hcbp_pkg::NUM_SYMBOLS-1:0]  written_q;

	logic                              v_s1;
	logic [1:0]                        cmd_s1;
	logic [LEN_CAP-1:0]                code_s1;
	logic [hcbp_pkg::CODE_LEN_W-1:0]   len_s1;
	logic                              written_s1;

	logic                              accept;
	logic [hcbp_pkg::CODE_LEN_W-1:0]   load_len;
	logic [LEN_CAP-1:0]                load_code;
	logic [hcbp_pkg::CODE_LEN_W-1:0]   eff_len;

	// Saturate the loaded length and keep only that many low code bits.
	always_comb begin
		load_len  = (code_len > LEN_CAP_V) ? LEN_CAP_V : code_len;
		load_code = code_bits[LEN_CAP-1:0] & ~({LEN_CAP{1'b1}} << load_len);
	end

	// Stage one moves on when empty, when its request is dropped, or when the queue has room.
	assign in_ready = !v_s1 || !push || !q_full;
	assign accept   = in_valid && in_ready;

	// Table write on load, registered table read for every accepted request.
	always_ff @(posedge clk) begin
		if (accept && cmd == hcbp_pkg::CMD_LOAD) begin
			code_mem[symbol] <= load_code;
			len_mem[symbol]  <= load_len;
		end
		if (accept) begin
			code_s1 <= code_mem[symbol];
			len_s1  <= len_mem[symbol];
		end
	end

	// Entries that were never loaded read as length zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			written_s1 <= 1'b0;
			v_s1       <= 1'b0;
			cmd_s1     <= hcbp_pkg::CMD_LOAD;
		end else begin
			if (accept && cmd == hcbp_pkg::CMD_LOAD) begin
				written_q[symbol] <= 1'b1;
			end
			if (accept) begin
				written_s1 <= written_q[symbol];
				cmd_s1     <= cmd;
				v_s1       <= 1'b1;
			end else if (in_ready) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// Only encodes with a nonzero code length and flushes go on to the back end.
	always_comb begin
		eff_len = written_s1 ? len_s1 : '0;
		case (cmd_s1)
			hcbp_pkg::CMD_ENCODE: push = v_s1 && (eff_len != '0);
			hcbp_pkg::CMD_FLUSH:  push = v_s1;
			default:              push = 1'b0;
		endcase
		push_data = {(cmd_s1 == hcbp_pkg::CMD_FLUSH), eff_len, code_s1};
	end

endmodule

>>> hw/rtl/hcbp_queue.sv
// Short FIFO that decouples table lookup from byte emission.
module hcbp_queue #(
	parameter int WIDTH = 39,
	parameter int DEPTH = hcbp_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count, wrapping at the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/hcbp_back.sv
// Back end: bit accumulator that merges codes and emits packed bytes.
module hcbp_back #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_not_empty,
	input  logic [hcbp_pkg::len_cap(MAX_CODE_LEN)+hcbp_pkg::CODE_LEN_W:0] q_head,
	output logic                                  q_pop,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic [hcbp_pkg::BYTE_W-1:0]           out_byte,
	output logic                                  last
);
	localparam int LEN_CAP = hcbp_pkg::len_cap(MAX_CODE_LEN);
	localparam int BW      = hcbp_pkg::BYTE_W;
	localparam int ACC_W   = LEN_CAP + BW;
	localparam int CNT_W   = $clog2(ACC_W);
	localparam int SH_W    = CNT_W + 1;

	// Accumulator is left aligned: the earliest pending bit sits at the top.
	logic [ACC_W-1:0]                  acc_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic                              res_v_q;
	logic [BW-1:0]                     byte_q;
	logic                              last_q;

	logic                              head_flush;
	logic [hcbp_pkg::CODE_LEN_W-1:0]   head_len;
	logic [LEN_CAP-1:0]                head_code;
	logic                              slot_free;
	logic                              emit;
	logic [ACC_W-1:0]                  acc_base;
	logic [CNT_W-1:0]                  cnt_base;
	logic                              pop_enc;
	logic                              pop_flush;
	logic [SH_W-1:0]                   shamt;
	logic [ACC_W-1:0]                  placed;

	assign {head_flush, head_len, head_code} = q_head;

	// Emit a byte whenever a whole one is pending and the output slot is free; merge the next code once fewer remain.
	always_comb begin
		slot_free = !res_v_q || res_ready;
		emit      = slot_free && (cnt_q >= CNT_W'(BW));
		acc_base  = emit ? (acc_q << BW) : acc_q;
		cnt_base  = emit ? (cnt_q - CNT_W'(BW)) : cnt_q;
		pop_enc   = q_not_empty && !head_flush && (cnt_base < CNT_W'(BW));
		pop_flush = q_not_empty && head_flush && !emit && slot_free
			&& (cnt_q < CNT_W'(BW));
		q_pop     = pop_enc || pop_flush;
		shamt     = SH_W'(ACC_W) - SH_W'(cnt_base) - SH_W'(head_len);
		placed    = ACC_W'(head_code) << shamt;
	end

	// Accumulator and pending count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (pop_flush) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (pop_enc) begin
			acc_q <= acc_base | placed;
			cnt_q <= cnt_base + CNT_W'(head_len);
		end else begin
			acc_q <= acc_base;
			cnt_q <= cnt_base;
		end
	end

	// Output register; last marks a byte after which less than a whole byte stays pending.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			byte_q  <= '0;
			last_q  <= 1'b0;
		end else if (emit) begin
			res_v_q <= 1'b1;
			byte_q  <= acc_q[ACC_W-1 -: BW];
			last_q  <= (cnt_base < CNT_W'(BW));
		end else if (pop_flush && cnt_q != '0) begin
			res_v_q <= 1'b1;
			byte_q  <= acc_q[ACC_W-1 -: BW];
			last_q  <= 1'b1;
		end else if (res_ready) begin
			res_v_q <= 1'b0;
		end
	end

	assign res_valid = res_v_q;
	assign out_byte  = byte_q;
	assign last      = last_q;

endmodule

>>> hw/rtl/huffman_code_bit_packer_unit.sv
// Top level of the Huffman code bit packer: front end, queue and back end.
//
//  channel  dir  handshake     payload
//  item     in   valid/ready   cmd, symbol, code_bits, code_len
//  result   out  valid/ready   out_byte, last
//
// A request is looked up in the code table in the cycle after it is taken and
// then waits in a four-entry queue. Loads, unknown commands and encodes of
// zero-length codes end at the lookup. An encode yields at most four bytes,
// which leave one per handshake through the byte-wide output register.
// Reset clears the length table's written flags and the accumulator at once,
// so requests are taken from the first cycle after reset. A stalled result
// holds the back end only; the front keeps taking requests until the queue fills.
module huffman_code_bit_packer_unit #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	hcbp_item_if.sink     item,
	hcbp_result_if.source result
);
	localparam int LEN_CAP = hcbp_pkg::len_cap(MAX_CODE_LEN);
	localparam int ENT_W   = LEN_CAP + hcbp_pkg::CODE_LEN_W + 1;

	logic             push;
	logic             q_full;
	logic [ENT_W-1:0] push_data;
	logic             q_pop;
	logic             q_not_empty;
	logic [ENT_W-1:0] q_head;

	hcbp_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.cmd       (item.cmd),
		.symbol    (item.symbol),
		.code_bits (item.code_bits),
		.code_len  (item.code_len),
		.push      (push),
		.q_full    (q_full),
		.push_data (push_data)
	);

	hcbp_queue #(
		.WIDTH(ENT_W),
		.DEPTH(hcbp_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	hcbp_back #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.out_byte    (result.out_byte),
		.last        (result.last)
	);

endmodule
